/* rtl/xrps_pkg.sv */
// Shared types and constants of the x86 reference pattern scanner.
package xrps_pkg;

	localparam int ADDR_BITS = 6;
	localparam int NUM_EXEC  = 2;
	localparam int MAX_HITS  = 3;
	localparam int QDEPTH    = 8;
	localparam int QPTR_BITS = $clog2(QDEPTH);
	localparam int QCNT_BITS = QPTR_BITS + 1;

	localparam logic [2:0] REG_SECTION_BASE = 3'd0;
	localparam logic [2:0] REG_IMAGE_LOW    = 3'd1;
	localparam logic [2:0] REG_IMAGE_HIGH   = 3'd2;
	localparam logic [2:0] REG_EXEC0_BEGIN  = 3'd3;
	localparam logic [2:0] REG_EXEC0_END    = 3'd4;
	localparam logic [2:0] REG_EXEC1_BEGIN  = 3'd5;
	localparam logic [2:0] REG_EXEC1_END    = 3'd6;

	localparam logic [1:0] KIND_LEA  = 2'd0;
	localparam logic [1:0] KIND_CALL = 2'd1;
	localparam logic [1:0] KIND_SLOT = 2'd2;

	localparam logic [7:0] OP_REX_W   = 8'h48;
	localparam logic [7:0] OP_REX_WR  = 8'h4C;
	localparam logic [7:0] OP_LEA     = 8'h8D;
	localparam logic [7:0] MODRM_MASK = 8'hC7;
	localparam logic [7:0] MODRM_RIP  = 8'h05;
	localparam logic [7:0] OP_CALL    = 8'hE8;
	localparam logic [7:0] OP_GRP5    = 8'hFF;
	localparam logic [7:0] MODRM_CALL = 8'h15;
	localparam logic [7:0] MODRM_JMP  = 8'h25;

	localparam logic [63:0] LEA_BACK  = 64'd6;
	localparam logic [63:0] SLOT_BACK = 64'd5;
	localparam logic [63:0] CALL_BACK = 64'd4;

	typedef struct packed {
		logic [1:0]  kind;
		logic [63:0] site;
		logic [63:0] target;
		logic        last;
	} ref_item_t;

	typedef struct packed {
		logic             valid;
		logic [6:0][7:0]  win;
		logic [63:0]      here;
	} front_s1_t;

	typedef struct packed {
		logic                valid;
		logic [2:0]          hit;
		ref_item_t [2:0]     item;
	} match_bundle_t;

	typedef struct packed {
		logic [63:0]                image_low;
		logic [63:0]                image_high;
		logic [NUM_EXEC-1:0][63:0]  exec_begin;
		logic [NUM_EXEC-1:0][63:0]  exec_end;
	} cfg_bounds_t;

	typedef struct packed {
		logic                 room;
		logic [QCNT_BITS-1:0] count;
	} queue_status_t;

endpackage

/* rtl/xrps_front.sv */
// Byte history, position counter and first pipeline stage of the scanner.
module xrps_front #(
	parameter int POSITION_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 advance,
	input  logic                 in_valid,
	input  logic [7:0]           code_byte,
	input  logic                 section_end,
	input  logic [63:0]          section_base,
	output xrps_pkg::front_s1_t  s1
);

	logic [5:0][7:0]          hist_q;
	logic [POSITION_BITS-1:0] pos_q;
	logic [6:0][7:0]          win;
	logic                     accept;

	assign accept = in_valid & advance;
	assign win    = {code_byte, hist_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q <= '0;
			pos_q  <= '0;
		end else if (accept) begin
			if (section_end) begin
				hist_q <= '0;
				pos_q  <= '0;
			end else begin
				hist_q <= win[6:1];
				pos_q  <= pos_q + POSITION_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1 <= '0;
		end else if (advance) begin
			s1.valid <= accept;
			if (accept) begin
				s1.win  <= win;
				s1.here <= section_base + 64'(pos_q);
			end
		end
	end

endmodule

/* rtl/xrps_match.sv */
// Pattern match, target arithmetic and range checks of the scanner.
module xrps_match #(
	parameter int EXEC_RANGES = 2
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    advance,
	input  xrps_pkg::front_s1_t     s1,
	input  xrps_pkg::cfg_bounds_t   bounds,
	output xrps_pkg::match_bundle_t bundle
);

	logic        valid_s2;
	logic        is_lea_s2;
	logic        is_slot_s2;
	logic        is_call_s2;
	logic [63:0] next_s2;
	logic [63:0] site_lea_s2;
	logic [63:0] site_slot_s2;
	logic [63:0] site_call_s2;

	logic [63:0] disp;
	logic [xrps_pkg::NUM_EXEC-1:0] exec_hit;
	logic        in_image;
	logic        in_exec;

	// The displacement is always the last four bytes of the window.
	assign disp = {{32{s1.win[6][7]}}, s1.win[6], s1.win[5], s1.win[4], s1.win[3]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= s1.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			next_s2      <= s1.here + disp + 64'd1;
			site_lea_s2  <= s1.here - xrps_pkg::LEA_BACK;
			site_slot_s2 <= s1.here - xrps_pkg::SLOT_BACK;
			site_call_s2 <= s1.here - xrps_pkg::CALL_BACK;
			is_lea_s2    <= (s1.win[0] == xrps_pkg::OP_REX_W || s1.win[0] == xrps_pkg::OP_REX_WR)
				&& s1.win[1] == xrps_pkg::OP_LEA
				&& (s1.win[2] & xrps_pkg::MODRM_MASK) == xrps_pkg::MODRM_RIP;
			is_slot_s2   <= s1.win[1] == xrps_pkg::OP_GRP5
				&& (s1.win[2] == xrps_pkg::MODRM_CALL || s1.win[2] == xrps_pkg::MODRM_JMP);
			is_call_s2   <= s1.win[2] == xrps_pkg::OP_CALL;
		end
	end

	// Only the first EXEC_RANGES ranges take part; an empty range holds nothing.
	for (genvar i = 0; i < xrps_pkg::NUM_EXEC; i++) begin : g_exec
		assign exec_hit[i] = (i < EXEC_RANGES)
			&& next_s2 >= bounds.exec_begin[i] && next_s2 < bounds.exec_end[i];
	end

	assign in_exec  = |exec_hit;
	assign in_image = next_s2 >= bounds.image_low && next_s2 < bounds.image_high;

	always_comb begin
		bundle.valid  = valid_s2;
		bundle.hit[0] = valid_s2 & is_lea_s2;
		bundle.hit[1] = valid_s2 & is_slot_s2 & in_image;
		bundle.hit[2] = valid_s2 & is_call_s2 & in_exec;

		bundle.item[0].kind   = xrps_pkg::KIND_LEA;
		bundle.item[0].site   = site_lea_s2;
		bundle.item[0].target = next_s2;
		bundle.item[0].last   = ~bundle.hit[1] & ~bundle.hit[2];

		bundle.item[1].kind   = xrps_pkg::KIND_SLOT;
		bundle.item[1].site   = site_slot_s2;
		bundle.item[1].target = next_s2;
		bundle.item[1].last   = ~bundle.hit[2];

		bundle.item[2].kind   = xrps_pkg::KIND_CALL;
		bundle.item[2].site   = site_call_s2;
		bundle.item[2].target = next_s2;
		bundle.item[2].last   = 1'b1;
	end

endmodule

/* rtl/xrps_queue.sv */
// Result queue that takes up to three results per cycle and hands out one.
module xrps_queue (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	input  xrps_pkg::match_bundle_t   bundle,
	input  logic                      out_ready,
	output logic                      out_valid,
	output xrps_pkg::ref_item_t       head_item,
	output xrps_pkg::queue_status_t   status
);

	localparam int PB = xrps_pkg::QPTR_BITS;
	localparam int CB = xrps_pkg::QCNT_BITS;

	xrps_pkg::ref_item_t mem_q [xrps_pkg::QDEPTH];
	logic [PB-1:0] head_q;
	logic [PB-1:0] tail_q;
	logic [CB-1:0] count_q;

	logic [2:0][1:0] offset;
	logic [1:0]      n_push;
	logic            pop;

	assign offset[0] = 2'd0;
	assign offset[1] = {1'b0, bundle.hit[0]};
	assign offset[2] = {1'b0, bundle.hit[0]} + {1'b0, bundle.hit[1]};
	assign n_push    = push ? offset[2] + {1'b0, bundle.hit[2]} : 2'd0;

	assign out_valid    = count_q != '0;
	assign pop          = out_valid & out_ready;
	assign head_item    = mem_q[head_q];
	assign status.count = count_q;
	assign status.room  = count_q <= CB'(xrps_pkg::QDEPTH - xrps_pkg::MAX_HITS);

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			if (push && bundle.hit[k]) begin
				mem_q[tail_q + PB'(offset[k])] <= bundle.item[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			tail_q  <= tail_q + PB'(n_push);
			head_q  <= head_q + PB'(pop);
			count_q <= count_q + CB'(n_push) - CB'(pop);
		end
	end

endmodule

/* rtl/x86_reference_pattern_scanner.sv */
// Top level of the x86 reference pattern scanner with its register port.
//
// The scanner takes one section byte per beat and reports RIP-relative lea
// sites, direct calls whose target lies in an executable range, and indirect
// calls or jumps through a slot inside the image. It accepts one byte every
// cycle while in_ready is high. Bytes flow through three registered steps:
// history and base-plus-position add, target add and pattern compare, then
// the range checks that write all results of a byte into an eight-entry
// queue at once. in_ready drops only while that queue has fewer than three
// free entries and a byte waits to be written, so a stalled output side
// holds the input back once six results wait in the queue. Results of one
// byte leave in site order, the last one marked with last_of_run. The seven
// 64-bit registers sit at byte addresses 0, 8, ..., 48 and should be written
// only while the scanner is idle.
module x86_reference_pattern_scanner #(
	parameter int EXEC_RANGES   = 2,
	parameter int POSITION_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [xrps_pkg::ADDR_BITS-1:0] paddr,
	input  logic [63:0]                   pwdata,
	output logic [63:0]                   prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [7:0]                    code_byte,
	input  logic                          section_end,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [1:0]                    ref_kind,
	output logic [63:0]                   site_address,
	output logic [63:0]                   target_address,
	output logic                          last_of_run
);

	logic [63:0] section_base_q;
	logic [63:0] image_low_q;
	logic [63:0] image_high_q;
	logic [63:0] exec0_begin_q;
	logic [63:0] exec0_end_q;
	logic [63:0] exec1_begin_q;
	logic [63:0] exec1_end_q;

	logic       cfg_write;
	logic [2:0] reg_index;

	xrps_pkg::cfg_bounds_t   bounds;
	xrps_pkg::front_s1_t     s1;
	xrps_pkg::match_bundle_t bundle;
	xrps_pkg::queue_status_t qstat;
	xrps_pkg::ref_item_t     head_item;
	logic                    advance;

	// Register port: every access completes in its access cycle.
	assign pready    = 1'b1;
	assign cfg_write = psel & penable & pwrite;
	assign reg_index = paddr[5:3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			section_base_q <= '0;
			image_low_q    <= '0;
			image_high_q   <= '0;
			exec0_begin_q  <= '0;
			exec0_end_q    <= '0;
			exec1_begin_q  <= '0;
			exec1_end_q    <= '0;
		end else if (cfg_write) begin
			case (reg_index)
				xrps_pkg::REG_SECTION_BASE: section_base_q <= pwdata;
				xrps_pkg::REG_IMAGE_LOW:    image_low_q    <= pwdata;
				xrps_pkg::REG_IMAGE_HIGH:   image_high_q   <= pwdata;
				xrps_pkg::REG_EXEC0_BEGIN:  exec0_begin_q  <= pwdata;
				xrps_pkg::REG_EXEC0_END:    exec0_end_q    <= pwdata;
				xrps_pkg::REG_EXEC1_BEGIN:  exec1_begin_q  <= pwdata;
				xrps_pkg::REG_EXEC1_END:    exec1_end_q    <= pwdata;
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_index)
			xrps_pkg::REG_SECTION_BASE: prdata = section_base_q;
			xrps_pkg::REG_IMAGE_LOW:    prdata = image_low_q;
			xrps_pkg::REG_IMAGE_HIGH:   prdata = image_high_q;
			xrps_pkg::REG_EXEC0_BEGIN:  prdata = exec0_begin_q;
			xrps_pkg::REG_EXEC0_END:    prdata = exec0_end_q;
			xrps_pkg::REG_EXEC1_BEGIN:  prdata = exec1_begin_q;
			xrps_pkg::REG_EXEC1_END:    prdata = exec1_end_q;
			default:                    prdata = '0;
		endcase
	end

	assign bounds.image_low     = image_low_q;
	assign bounds.image_high    = image_high_q;
	assign bounds.exec_begin[0] = exec0_begin_q;
	assign bounds.exec_end[0]   = exec0_end_q;
	assign bounds.exec_begin[1] = exec1_begin_q;
	assign bounds.exec_end[1]   = exec1_end_q;

	// The whole pipeline moves together. It holds only when the last step
	// carries a byte and the queue cannot take a full set of three results.
	assign advance  = ~bundle.valid | qstat.room;
	assign in_ready = advance;

	xrps_front #(
		.POSITION_BITS(POSITION_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (advance),
		.in_valid     (in_valid),
		.code_byte    (code_byte),
		.section_end  (section_end),
		.section_base (section_base_q),
		.s1           (s1)
	);

	xrps_match #(
		.EXEC_RANGES(EXEC_RANGES)
	) u_match (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.s1      (s1),
		.bounds  (bounds),
		.bundle  (bundle)
	);

	xrps_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (advance & bundle.valid),
		.bundle    (bundle),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.head_item (head_item),
		.status    (qstat)
	);

	assign ref_kind       = head_item.kind;
	assign site_address   = head_item.site;
	assign target_address = head_item.target;
	assign last_of_run    = head_item.last;

	// The queue never holds more entries than it has.
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		qstat.count <= xrps_pkg::QCNT_BITS'(xrps_pkg::QDEPTH))
		else $error("result queue overfilled");

	// Input is held back only while the last step has a byte to write.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> bundle.valid && !qstat.room)
		else $error("input stalled without a waiting byte");

	// All results of one byte enter the queue together, so the rest of a
	// run is already there when an earlier beat of it is taken.
	a_run_whole: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_of_run |=> out_valid)
		else $error("run of results broken up");

endmodule

/* dv/tb_top.sv */
// Self-checking testbench for the x86 reference pattern scanner.
module tb_top;

	// Index 7 decodes to no register, so a write there must be ignored.
	localparam logic [2:0] REG_SPARE = 3'd7;

	// One section byte waiting to be driven, with the idle cycles that precede it.
	typedef struct {
		logic [7:0] data;
		logic       eos;
		int         gap;
	} code_beat_t;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int SETTLE_CYCLES = 8;

	logic                clk         = 1'b0;
	logic                arst_n      = 1'b0;
	logic                psel        = 1'b0;
	logic                penable     = 1'b0;
	logic                pwrite      = 1'b0;
	logic [xrps_pkg::ADDR_BITS-1:0] paddr = '0;
	logic [63:0]         pwdata      = '0;
	logic [63:0]         prdata;
	logic                pready;
	logic                in_valid    = 1'b0;
	logic                in_ready;
	logic [7:0]          code_byte   = 8'h00;
	logic                section_end = 1'b0;
	logic                out_valid;
	logic                out_ready   = 1'b0;
	logic [1:0]          ref_kind;
	logic [63:0]         site_address;
	logic [63:0]         target_address;
	logic                last_of_run;

	x86_reference_pattern_scanner DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.code_byte      (code_byte),
		.section_end    (section_end),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.ref_kind       (ref_kind),
		.site_address   (site_address),
		.target_address (target_address),
		.last_of_run    (last_of_run)
	);

	// Shadow copy of the register file, updated at the edge that writes the real one.
	logic [63:0] sec_base = '0;
	logic [63:0] img_lo   = '0;
	logic [63:0] img_hi   = '0;
	logic [63:0] x0_lo    = '0;
	logic [63:0] x0_hi    = '0;
	logic [63:0] x1_lo    = '0;
	logic [63:0] x1_hi    = '0;

	// Shadow scanner state: the last six bytes seen and the position in the section.
	logic [7:0]  seen [6] = '{default: 8'h00};
	logic [31:0] seen_pos = '0;

	xrps_pkg::ref_item_t expected_refs [$];
	code_beat_t          byte_queue [$];

	// Driver staging: the beat popped from the queue while its idle gap runs out.
	code_beat_t next_beat;
	bit         staged    = 1'b0;
	int         wait_left = 0;
	int         stall_left = 0;

	// Knobs of the stimulus generator, changed between phases.
	int          in_gap_max  = 16;
	int          out_gap_max = 16;
	int          eos_pct     = 0;
	logic [31:0] gen_pos     = '0;
	int          gen_count   = 0;

	int fail_count = 0;
	int cycle_count = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	// Watchdog. A hung handshake or a result that never shows up ends here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Idle cycles for one beat. At least a quarter of the draws are zero so
	// that back-to-back stretches show up even when the maximum is large.
	function automatic int draw_gap(input int max_gap);
		if (max_gap == 0 || $urandom_range(0, 3) == 0)
			return 0;
		return $urandom_range(0, max_gap);
	endfunction

	// Predicts the results caused by one accepted byte and advances the
	// shadow history. A lea needs 8D in the second slot and an indirect branch
	// needs FF there, and the third slot values of a call and a lea never
	// overlap, so in practice one byte completes at most one site; the code
	// still handles several and marks the last of them.
	task automatic scan_byte(input logic [7:0] b, input logic eos);
		logic [7:0]          w [7];
		logic [31:0]         raw;
		logic [63:0]         here;
		logic [63:0]         nxt;
		xrps_pkg::ref_item_t hits [3];
		int                  n;
		int                  i;
		n = 0;
		for (i = 0; i < 6; i++)
			w[i] = seen[i];
		w[6] = b;
		raw  = {w[6], w[5], w[4], w[3]};
		here = sec_base + {32'd0, seen_pos};
		nxt  = here + 64'd1 + {{32{raw[31]}}, raw};
		if ((w[0] == xrps_pkg::OP_REX_W || w[0] == xrps_pkg::OP_REX_WR) &&
		    w[1] == xrps_pkg::OP_LEA &&
		    (w[2] & xrps_pkg::MODRM_MASK) == xrps_pkg::MODRM_RIP) begin
			hits[n].kind   = xrps_pkg::KIND_LEA;
			hits[n].site   = here - xrps_pkg::LEA_BACK;
			hits[n].target = nxt;
			hits[n].last   = 1'b0;
			n++;
		end
		if (w[1] == xrps_pkg::OP_GRP5 &&
		    (w[2] == xrps_pkg::MODRM_CALL || w[2] == xrps_pkg::MODRM_JMP) &&
		    nxt >= img_lo && nxt < img_hi) begin
			hits[n].kind   = xrps_pkg::KIND_SLOT;
			hits[n].site   = here - xrps_pkg::SLOT_BACK;
			hits[n].target = nxt;
			hits[n].last   = 1'b0;
			n++;
		end
		if (w[2] == xrps_pkg::OP_CALL &&
		    ((nxt >= x0_lo && nxt < x0_hi) || (nxt >= x1_lo && nxt < x1_hi))) begin
			hits[n].kind   = xrps_pkg::KIND_CALL;
			hits[n].site   = here - xrps_pkg::CALL_BACK;
			hits[n].target = nxt;
			hits[n].last   = 1'b0;
			n++;
		end
		if (n > 0)
			hits[n - 1].last = 1'b1;
		for (i = 0; i < n; i++)
			expected_refs.insert(expected_refs.size(), hits[i]);
		// The final byte of a section is matched first, then everything clears.
		if (eos) begin
			for (i = 0; i < 6; i++)
				seen[i] = 8'h00;
			seen_pos = '0;
		end else begin
			for (i = 0; i < 6; i++)
				seen[i] = w[i + 1];
			seen_pos = seen_pos + 32'd1;
		end
	endtask

	// Input driver. A beat is offered only after its idle gap has elapsed and
	// is then held until the scanner takes it.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid    <= 1'b0;
			code_byte   <= 8'h00;
			section_end <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				scan_byte(code_byte, section_end);
			if (!in_valid || in_ready) begin
				if (!staged && byte_queue.size() != 0) begin
					next_beat = byte_queue.pop_front();
					staged    = 1'b1;
					wait_left = next_beat.gap;
				end
				if (staged && wait_left == 0) begin
					in_valid    <= 1'b1;
					code_byte   <= next_beat.data;
					section_end <= next_beat.eos;
					staged      = 1'b0;
				end else begin
					in_valid <= 1'b0;
					if (wait_left > 0)
						wait_left--;
				end
			end
		end
	end

	task automatic check_field(input string name, input logic [63:0] want,
	                           input logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected %h, got %h", name, want, got);
			fail_count++;
		end
	endtask

	// Result monitor. Every accepted result beat is matched against the oldest
	// prediction; after each one the receiver may stall for a while.
	always @(posedge clk or negedge arst_n) begin
		xrps_pkg::ref_item_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_refs.size() == 0) begin
					$error("unexpected result: kind %0d site %h target %h",
					       ref_kind, site_address, target_address);
					fail_count++;
				end else begin
					want = expected_refs.pop_front();
					check_field("ref_kind", 64'(want.kind), 64'(ref_kind));
					check_field("site_address", want.site, site_address);
					check_field("target_address", want.target, target_address);
					check_field("last_of_run", 64'(want.last), 64'(last_of_run));
				end
				stall_left = draw_gap(out_gap_max);
			end
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// One register write: setup cycle, then access cycle until pready.
	task automatic cfg_write(input logic [2:0] r, input logic [63:0] v);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {r, 3'b000};
		pwdata  <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (r)
			xrps_pkg::REG_SECTION_BASE: sec_base = v;
			xrps_pkg::REG_IMAGE_LOW:    img_lo   = v;
			xrps_pkg::REG_IMAGE_HIGH:   img_hi   = v;
			xrps_pkg::REG_EXEC0_BEGIN:  x0_lo    = v;
			xrps_pkg::REG_EXEC0_END:    x0_hi    = v;
			xrps_pkg::REG_EXEC1_BEGIN:  x1_lo    = v;
			xrps_pkg::REG_EXEC1_END:    x1_hi    = v;
			default: ;
		endcase
	endtask

	task automatic set_config(input logic [63:0] base, input logic [63:0] ilo,
	                          input logic [63:0] ihi, input logic [63:0] e0lo,
	                          input logic [63:0] e0hi, input logic [63:0] e1lo,
	                          input logic [63:0] e1hi);
		cfg_write(xrps_pkg::REG_SECTION_BASE, base);
		cfg_write(xrps_pkg::REG_IMAGE_LOW, ilo);
		cfg_write(xrps_pkg::REG_IMAGE_HIGH, ihi);
		cfg_write(xrps_pkg::REG_EXEC0_BEGIN, e0lo);
		cfg_write(xrps_pkg::REG_EXEC0_END, e0hi);
		cfg_write(xrps_pkg::REG_EXEC1_BEGIN, e1lo);
		cfg_write(xrps_pkg::REG_EXEC1_END, e1hi);
	endtask

	// Waits until every byte is in and every result is out, then lets the
	// pipeline run empty so that no late result is still in flight when the
	// registers change.
	task automatic drain();
		while (byte_queue.size() != 0 || staged || in_valid || expected_refs.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Queues one byte. With eos_pct set, a section may end on any byte, which
	// also cuts patterns short.
	task automatic put_byte(input logic [7:0] b, input logic eos);
		code_beat_t beat;
		beat.data = b;
		beat.eos  = eos || (eos_pct != 0 && $urandom_range(0, 99) < eos_pct);
		beat.gap  = draw_gap(in_gap_max);
		byte_queue.insert(byte_queue.size(), beat);
		gen_count++;
		if (beat.eos)
			gen_pos = '0;
		else
			gen_pos = gen_pos + 32'd1;
	endtask

	// Displacement that makes a pattern of len bytes, starting at the next
	// queued byte, reference the given address.
	function automatic logic [31:0] disp_to(input logic [63:0] target, input int len);
		logic [31:0] last_pos;
		logic [63:0] d;
		last_pos = gen_pos + 32'(len - 1);
		d = target - (sec_base + {32'd0, last_pos} + 64'd1);
		return d[31:0];
	endfunction

	task automatic put_disp(input logic [31:0] d, input logic eos_last);
		put_byte(d[7:0], 1'b0);
		put_byte(d[15:8], 1'b0);
		put_byte(d[23:16], 1'b0);
		put_byte(d[31:24], eos_last);
	endtask

	task automatic put_lea(input logic [7:0] rex, input logic [7:0] modrm,
	                       input logic [31:0] d, input logic eos_last);
		put_byte(rex, 1'b0);
		put_byte(xrps_pkg::OP_LEA, 1'b0);
		put_byte(modrm, 1'b0);
		put_disp(d, eos_last);
	endtask

	task automatic put_slot(input logic [7:0] modrm, input logic [31:0] d,
	                        input logic eos_last);
		put_byte(xrps_pkg::OP_GRP5, 1'b0);
		put_byte(modrm, 1'b0);
		put_disp(d, eos_last);
	endtask

	task automatic put_call(input logic [31:0] d, input logic eos_last);
		put_byte(xrps_pkg::OP_CALL, 1'b0);
		put_disp(d, eos_last);
	endtask

	// An address at or around the edges of [lo, hi), inside it, or anywhere.
	function automatic logic [63:0] pick_near(input logic [63:0] lo, input logic [63:0] hi);
		case ($urandom_range(0, 5))
			0: return lo;
			1: return hi - 64'd1;
			2: return hi;
			3: return lo - 64'd1;
			4: return (hi > lo) ? lo + ({$urandom, $urandom} % (hi - lo)) : lo;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// Mostly complete patterns with random content; the rest is noise that is
	// biased toward opcode and prefix bytes so partial patterns come up often.
	task automatic random_stream(input int n_bytes);
		int          stop_at;
		logic [7:0]  modrm;
		logic [63:0] target;
		stop_at = gen_count + n_bytes;
		while (gen_count < stop_at) begin
			case ($urandom_range(0, 9))
				0, 1, 2: begin
					modrm = ($urandom_range(0, 3) == 0) ? 8'($urandom) :
					        {2'b00, 3'($urandom), 3'b101};
					target = pick_near(x0_lo, img_hi);
					put_lea($urandom_range(0, 1) ? xrps_pkg::OP_REX_W : xrps_pkg::OP_REX_WR,
					        modrm, disp_to(target, 7), 1'b0);
				end
				3, 4: begin
					target = pick_near(img_lo, img_hi);
					put_slot($urandom_range(0, 1) ? xrps_pkg::MODRM_CALL : xrps_pkg::MODRM_JMP,
					         disp_to(target, 6), 1'b0);
				end
				5, 6: begin
					target = $urandom_range(0, 1) ? pick_near(x0_lo, x0_hi) :
					         pick_near(x1_lo, x1_hi);
					put_call(disp_to(target, 5), 1'b0);
				end
				default: begin
					repeat ($urandom_range(1, 4)) begin
						case ($urandom_range(0, 11))
							0: put_byte(xrps_pkg::OP_REX_W, 1'b0);
							1: put_byte(xrps_pkg::OP_REX_WR, 1'b0);
							2: put_byte(xrps_pkg::OP_LEA, 1'b0);
							3: put_byte(xrps_pkg::OP_GRP5, 1'b0);
							4: put_byte(xrps_pkg::OP_CALL, 1'b0);
							5: put_byte(xrps_pkg::MODRM_CALL, 1'b0);
							6: put_byte(xrps_pkg::MODRM_JMP, 1'b0);
							7: put_byte(xrps_pkg::MODRM_RIP, 1'b0);
							default: put_byte(8'($urandom), 1'b0);
						endcase
					end
				end
			endcase
		end
	endtask

	initial begin
		logic [63:0] base;
		logic [63:0] span;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Phase one: a typical image layout. The write to the spare address
		// must leave every register alone.
		set_config(64'h0000_0001_4000_1000, 64'h0000_0001_4000_0000,
		           64'h0000_0001_4010_0000, 64'h0000_0001_4000_1000,
		           64'h0000_0001_4005_0000, 64'h0000_0001_4008_0000,
		           64'h0000_0001_4009_0000);
		cfg_write(REG_SPARE, {$urandom, $urandom});
		in_gap_max  = 16;
		out_gap_max = 16;
		eos_pct     = 0;

		// Directed bytes. A lea with the most negative displacement, a jump
		// through the last slot inside the image, and a call whose last byte
		// is also the last byte of the section, which must still be reported.
		put_lea(xrps_pkg::OP_REX_W, xrps_pkg::MODRM_RIP, 32'h8000_0000, 1'b0);
		put_slot(xrps_pkg::MODRM_JMP, disp_to(img_hi - 64'd1, 6), 1'b0);
		put_call(disp_to(x1_lo, 5), 1'b1);
		// A new section starts at position zero; this lea has the largest
		// positive displacement and another register field in the ModRM byte.
		put_lea(xrps_pkg::OP_REX_WR, 8'h3D, 32'h7FFF_FFFF, 1'b0);
		// A lea cut short by the section end must never be reported, and the
		// bytes after it start from a clean history.
		put_byte(xrps_pkg::OP_REX_WR, 1'b0);
		put_byte(xrps_pkg::OP_LEA, 1'b0);
		put_byte(xrps_pkg::MODRM_RIP, 1'b0);
		put_byte(8'h00, 1'b1);
		put_byte(8'hFF, 1'b0);
		put_byte(8'hFF, 1'b0);

		eos_pct = 2;
		random_stream(100);
		drain();

		// Phase two: extreme registers with no idling on either side. Site
		// addresses wrap around the top of the address space, the image and
		// the first range cover everything but the last address, and the
		// second range is inverted.
		set_config(64'hFFFF_FFFF_FFFF_FFF0, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF,
		           64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0);
		in_gap_max  = 0;
		out_gap_max = 0;
		random_stream(100);
		drain();

		// Phase three: every range empty, so only lea sites come out, with
		// frequent section ends and heavy idling.
		set_config(64'h0, 64'h5, 64'h5, 64'hFFFF_FFFF_FFFF_FFFF,
		           64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 64'h0);
		in_gap_max  = 16;
		out_gap_max = 16;
		eos_pct     = 6;
		random_stream(60);
		drain();

		// Phase four: a random layout around a random base, the first range
		// inverted half of the time, with a slow receiver.
		base = {$urandom, $urandom & 32'hFFFF_F000};
		span = 64'($urandom_range(16, 32'h0010_0000));
		if ($urandom_range(0, 1) == 0)
			set_config(base, base - 64'($urandom_range(0, 32'h000F_FFFF)), base + span,
			           base, base + (span >> 1), base + span, base + span + 64'h4000);
		else
			set_config(base, base - 64'($urandom_range(0, 32'h000F_FFFF)), base + span,
			           base + span, base, base - 64'h8000, base + (span >> 2));
		in_gap_max  = 4;
		out_gap_max = 16;
		eos_pct     = 2;
		random_stream(140);
		drain();

		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
